### rtl/pcd_pkg.sv
package pcd_pkg;

  localparam int DATA_WIDTH    = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_BITS      = 32;
  localparam int CFG_W         = 48;

  typedef enum logic [0:0] {
    REG_DIMENSION_MODE  = 1'b0,
    REG_MIN_SPEED_CUBED = 1'b1
  } cfg_idx_t;

  localparam logic             MODE_RESET = 1'b1;
  localparam logic [CFG_W-1:0] THR_RESET  = 48'd43;

endpackage

### rtl/pcd_ifs.sv
interface pcd_item_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [pcd_pkg::DATA_WIDTH-1:0]     vel_x;
  logic signed [pcd_pkg::DATA_WIDTH-1:0]     vel_y;
  logic signed [pcd_pkg::DATA_WIDTH-1:0]     vel_z;
  logic signed [pcd_pkg::DATA_WIDTH-1:0]     acc_x;
  logic signed [pcd_pkg::DATA_WIDTH-1:0]     acc_y;
  logic signed [pcd_pkg::DATA_WIDTH-1:0]     acc_z;

  modport source (output valid, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, input ready);
  modport sink (input valid, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, output ready);
endinterface

interface pcd_result_if;
  logic                            valid;
  logic                            ready;
  logic [pcd_pkg::OUT_BITS-1:0]    curvature;
  logic                            speed_too_low;
  logic                            saturated;

  modport source (output valid, curvature, speed_too_low, saturated, input ready);
  modport sink (input valid, curvature, speed_too_low, saturated, output ready);
endinterface

### rtl/path_curvature_from_derivatives_unit.sv
// Curvature |v x a| / |v|^3 of a path from its velocity and acceleration, signed Q16.16 in,
// unsigned Q16.16 out, truncated toward zero and saturated at all ones. Planar mode ignores
// the z components. One item is taken per cycle while the skid register is empty. In order,
// seven stages of 32x32 partial products build the cross norm squared Q and the
// speed cubed S^3, one stage checks the threshold and the overflow, a 64-stage restoring
// divider forms floor(Q*2^(4F) / S^3) and a 32-stage digit-serial square root finishes.
// An output skid register lets one more item in while a result waits to be taken.
// A threshold write is squared through registered half-width limb products.
module path_curvature_from_derivatives_unit #(
  parameter int FRAC_BITS = pcd_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  pcd_item_if.sink                 item,
  pcd_result_if.source             result,
  input  logic                     cfg_we,
  input  pcd_pkg::cfg_idx_t        cfg_idx,
  input  logic [pcd_pkg::CFG_W-1:0] cfg_data
);
  import pcd_pkg::*;

  localparam int DW      = DATA_WIDTH;
  localparam int PW      = 2 * DW;
  localparam int QW      = 2 * PW;
  localparam int S3W     = 3 * PW;
  localparam int NW      = QW + 4 * FRAC_BITS;
  localparam int RW      = S3W + 1;
  localparam int QBITS   = 2 * OUT_BITS;
  localparam int SQ_N    = OUT_BITS;
  localparam int RMW     = OUT_BITS + 3;
  localparam int THW     = 2 * CFG_W;
  localparam int HW      = CFG_W / 2;
  localparam int SPW_L   = S3W + 64;
  localparam int SPW_R   = THW + 6 * FRAC_BITS;
  localparam int SPW     = (SPW_L > SPW_R) ? SPW_L : SPW_R;
  localparam int SATW    = (SPW_L > NW) ? SPW_L : NW;

  // configuration
  logic             mode;
  logic [CFG_W-1:0] thr;
  logic [CFG_W-1:0] thr_ll, thr_lh, thr_hh;
  logic [THW-1:0]   thr2;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RESET;
      thr  <= THR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DIMENSION_MODE:  mode <= cfg_data[0];
        REG_MIN_SPEED_CUBED: thr  <= cfg_data;
      endcase
    end
  end

  // square the threshold in half-width limbs, through registered limb products
  always_ff @(posedge clk) begin
    thr_ll <= thr[HW-1:0] * thr[HW-1:0];
    thr_lh <= thr[HW-1:0] * thr[CFG_W-1:HW];
    thr_hh <= thr[CFG_W-1:HW] * thr[CFG_W-1:HW];
    thr2   <= {thr_hh, thr_ll} + (THW'(thr_lh) << (HW + 1));
  end

  // flow control: the whole pipe holds while the skid register is full
  logic pipe_en;
  logic skid_full;
  logic item_xfer;

  assign pipe_en    = !skid_full;
  assign item.ready = pipe_en;
  assign item_xfer  = item.valid && pipe_en;

  // front stages
  logic [DW-1:0]    in_f [6];
  logic [DW-1:0]    s0_mag [6];
  logic             s0_sg [6];
  logic [PW-1:0]    s1_p [6];
  logic             s1_n [6];
  logic [PW-1:0]    s1_sq [3];
  logic [PW-1:0]    s2_c [3];
  logic [PW-1:0]    s2_s;
  logic [PW-1:0]    s3_ll [4];
  logic [PW-1:0]    s3_lh [4];
  logic [PW-1:0]    s3_hh [4];
  logic [PW-1:0]    s3_s;
  logic [QW-1:0]    s4_sq [4];
  logic [PW-1:0]    s4_s;
  logic [QW-1:0]    s5_q;
  logic [PW-1:0]    s5_pp [4][2];
  logic [QW-1:0]    s6_q;
  logic [S3W-1:0]   s6_s3;
  logic [S3W-1:0]   s3_acc;
  logic [PW-1:0]    c_src [4];
  logic [6:0]       fv;

  assign in_f[0] = item.vel_x;
  assign in_f[1] = item.vel_y;
  assign in_f[2] = mode ? item.vel_z : '0;
  assign in_f[3] = item.acc_x;
  assign in_f[4] = item.acc_y;
  assign in_f[5] = mode ? item.acc_z : '0;

  function automatic logic [PW-1:0] cross_abs(logic [PW-1:0] p, logic [PW-1:0] q,
                                              logic pn, logic qn);
    if (pn != qn) return p + q;
    else if (p >= q) return p - q;
    else return q - p;
  endfunction

  assign c_src[0] = s2_c[0];
  assign c_src[1] = s2_c[1];
  assign c_src[2] = s2_c[2];
  assign c_src[3] = s2_s;

  always_comb begin
    s3_acc = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 2; j++) begin
        s3_acc = s3_acc + (S3W'(s5_pp[i][j]) << (DW * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      // magnitude and sign
      for (int i = 0; i < 6; i++) begin
        s0_sg[i]  <= in_f[i][DW-1];
        s0_mag[i] <= in_f[i][DW-1] ? (~in_f[i] + 1'b1) : in_f[i];
      end
      // cross terms: x = vy*az - vz*ay, y = vz*ax - vx*az, z = vx*ay - vy*ax
      s1_p[0] <= s0_mag[1] * s0_mag[5];  s1_n[0] <= s0_sg[1] ^ s0_sg[5];
      s1_p[1] <= s0_mag[2] * s0_mag[4];  s1_n[1] <= s0_sg[2] ^ s0_sg[4];
      s1_p[2] <= s0_mag[2] * s0_mag[3];  s1_n[2] <= s0_sg[2] ^ s0_sg[3];
      s1_p[3] <= s0_mag[0] * s0_mag[5];  s1_n[3] <= s0_sg[0] ^ s0_sg[5];
      s1_p[4] <= s0_mag[0] * s0_mag[4];  s1_n[4] <= s0_sg[0] ^ s0_sg[4];
      s1_p[5] <= s0_mag[1] * s0_mag[3];  s1_n[5] <= s0_sg[1] ^ s0_sg[3];
      for (int i = 0; i < 3; i++) begin
        s1_sq[i] <= s0_mag[i] * s0_mag[i];
      end
      for (int i = 0; i < 3; i++) begin
        s2_c[i] <= cross_abs(s1_p[2*i], s1_p[2*i+1], s1_n[2*i], s1_n[2*i+1]);
      end
      s2_s <= s1_sq[0] + s1_sq[1] + s1_sq[2];
      // squares as limb partial products
      for (int i = 0; i < 4; i++) begin
        s3_ll[i] <= c_src[i][DW-1:0] * c_src[i][DW-1:0];
        s3_lh[i] <= c_src[i][DW-1:0] * c_src[i][PW-1:DW];
        s3_hh[i] <= c_src[i][PW-1:DW] * c_src[i][PW-1:DW];
      end
      s3_s <= s2_s;
      for (int i = 0; i < 4; i++) begin
        s4_sq[i] <= {s3_hh[i], s3_ll[i]} + (QW'(s3_lh[i]) << (DW + 1));
      end
      s4_s <= s3_s;
      s5_q <= s4_sq[0] + s4_sq[1] + s4_sq[2];
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 2; j++) begin
          s5_pp[i][j] <= s4_sq[3][DW*i +: DW] * s4_s[DW*j +: DW];
        end
      end
      s6_q  <= s5_q;
      s6_s3 <= s3_acc;
    end
  end

  // threshold and overflow checks, divider setup
  logic [SPW-1:0]  sp_lhs, sp_rhs;
  logic [SATW-1:0] sat_lhs, sat_rhs;
  logic [NW-1:0]   num;

  assign num     = {s6_q, {(4 * FRAC_BITS){1'b0}}};
  assign sp_lhs  = SPW'({s6_s3, 64'd0});
  assign sp_rhs  = SPW'({thr2, {(6 * FRAC_BITS){1'b0}}});
  assign sat_lhs = SATW'({s6_s3, 64'd0});
  assign sat_rhs = SATW'(num);

  // restoring divider, one quotient bit a stage
  logic [S3W-1:0]   div_r [QBITS+1];
  logic [QBITS-1:0] div_q [QBITS+1];
  logic [QBITS-1:0] div_n [QBITS+1];
  logic [S3W-1:0]   div_d [QBITS+1];
  logic [QBITS:0]   div_v, div_low, div_sat;
  logic [RW-1:0]    div_trial [QBITS];
  logic [RW:0]      div_diff [QBITS];

  always_comb begin
    for (int k = 0; k < QBITS; k++) begin
      div_trial[k] = {div_r[k], div_n[k][QBITS-1]};
      div_diff[k]  = {1'b0, div_trial[k]} - {2'b00, div_d[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      div_r[0]   <= S3W'(num[NW-1:QBITS]);
      div_n[0]   <= num[QBITS-1:0];
      div_q[0]   <= '0;
      div_d[0]   <= s6_s3;
      div_low[0] <= sp_lhs <= sp_rhs;
      div_sat[0] <= sat_lhs <= sat_rhs;
      for (int k = 0; k < QBITS; k++) begin
        div_r[k+1]   <= div_diff[k][RW] ? div_trial[k][S3W-1:0] : div_diff[k][S3W-1:0];
        div_q[k+1]   <= {div_q[k][QBITS-2:0], ~div_diff[k][RW]};
        div_n[k+1]   <= {div_n[k][QBITS-2:0], 1'b0};
        div_d[k+1]   <= div_d[k];
        div_low[k+1] <= div_low[k];
        div_sat[k+1] <= div_sat[k];
      end
    end
  end

  // digit-serial square root of the quotient, one root bit a stage
  logic [RMW-1:0]      sq_rem [1:SQ_N];
  logic [OUT_BITS-1:0] sq_root [1:SQ_N];
  logic [QBITS-1:0]    sq_k [1:SQ_N];
  logic [SQ_N:0]       sq_v;
  logic [SQ_N:1]       sq_low, sq_sat;
  logic [RMW-1:0]      sq_rem_in [SQ_N];
  logic [OUT_BITS-1:0] sq_root_in [SQ_N];
  logic [QBITS-1:0]    sq_k_in [SQ_N];
  logic [SQ_N-1:0]     sq_low_in, sq_sat_in;
  logic [RMW-1:0]      sq_trem [SQ_N];
  logic [RMW-1:0]      sq_try [SQ_N];
  logic                sq_ge [SQ_N];

  assign sq_v[0] = div_v[QBITS];

  always_comb begin
    // first root stage starts from the divider output and an empty remainder
    sq_rem_in[0]  = '0;
    sq_root_in[0] = '0;
    sq_k_in[0]    = div_q[QBITS];
    sq_low_in[0]  = div_low[QBITS];
    sq_sat_in[0]  = div_sat[QBITS];
    for (int j = 1; j < SQ_N; j++) begin
      sq_rem_in[j]  = sq_rem[j];
      sq_root_in[j] = sq_root[j];
      sq_k_in[j]    = sq_k[j];
      sq_low_in[j]  = sq_low[j];
      sq_sat_in[j]  = sq_sat[j];
    end
    for (int j = 0; j < SQ_N; j++) begin
      sq_trem[j] = {sq_rem_in[j][RMW-3:0], sq_k_in[j][QBITS-1 -: 2]};
      sq_try[j]  = {1'b0, sq_root_in[j], 2'b01};
      sq_ge[j]   = sq_trem[j] >= sq_try[j];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      for (int j = 0; j < SQ_N; j++) begin
        sq_rem[j+1]  <= sq_ge[j] ? (sq_trem[j] - sq_try[j]) : sq_trem[j];
        sq_root[j+1] <= {sq_root_in[j][OUT_BITS-2:0], sq_ge[j]};
        sq_k[j+1]    <= {sq_k_in[j][QBITS-3:0], 2'b00};
        sq_low[j+1]  <= sq_low_in[j];
        sq_sat[j+1]  <= sq_sat_in[j];
      end
    end
  end

  // valid bits advance with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      fv             <= '0;
      div_v          <= '0;
      sq_v[SQ_N:1]   <= '0;
    end else if (pipe_en) begin
      fv           <= {fv[5:0], item_xfer};
      div_v        <= {div_v[QBITS-1:0], fv[6]};
      sq_v[SQ_N:1] <= sq_v[SQ_N-1:0];
    end
  end

  // final result: a slow item reads zero, an overflowing one all ones
  logic                last_v;
  logic [OUT_BITS-1:0] last_curv;
  logic                last_low, last_sat;

  assign last_v    = sq_v[SQ_N];
  assign last_low  = sq_low[SQ_N];
  assign last_sat  = sq_sat[SQ_N] && !sq_low[SQ_N];
  assign last_curv = last_low ? '0 : (last_sat ? '1 : sq_root[SQ_N]);

  // skid register: catch the last stage when the sink stalls
  logic [OUT_BITS-1:0] skid_curv;
  logic                skid_low, skid_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (result.ready) skid_full <= 1'b0;
    end else if (last_v && !result.ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_curv <= last_curv;
      skid_low  <= last_low;
      skid_sat  <= last_sat;
    end
  end

  assign result.valid         = skid_full || last_v;
  assign result.curvature     = skid_full ? skid_curv : last_curv;
  assign result.speed_too_low = skid_full ? skid_low : last_low;
  assign result.saturated     = skid_full ? skid_sat : last_sat;

`ifndef SYNTHESIS
  a_low_not_sat: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.speed_too_low && result.saturated))
    else $error("slow item also flagged saturated");

  a_low_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.speed_too_low |-> result.curvature == '0)
    else $error("slow item with nonzero curvature");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(last_v && !result.ready))
    else $error("skid register filled without a stalled result");
`endif

endmodule

### tb/tb_path_curvature_from_derivatives_unit.sv
module tb_path_curvature_from_derivatives_unit;
  import pcd_pkg::*;

  typedef logic signed [DATA_WIDTH-1:0] comp_t;
  typedef logic [511:0] big_t;

  // One vector pair as it goes into the block.
  typedef struct packed {
    comp_t vx, vy, vz, ax, ay, az;
  } vec_pair_t;

  // One curvature result as it leaves the block.
  typedef struct packed {
    logic [OUT_BITS-1:0] curvature;
    logic                too_slow;
    logic                clipped;
  } curv_out_t;

  // Holds the curvature expected for each transfer in, oldest first, and checks results.
  class curvature_ledger;
    curv_out_t pending_curv[$];
    int        mismatches;

    function new();
      mismatches = 0;
    endfunction

    static function big_t mag_of(comp_t x);
      logic [DATA_WIDTH-1:0] m;
      m = x[DATA_WIDTH-1] ? (~x + 1'b1) : x;
      return big_t'(m);
    endfunction

    // |p*q - r*s| with every operand sign-extended before the multiply.
    static function big_t cross_term(comp_t p, comp_t q, comp_t r, comp_t s);
      logic signed [69:0] d;
      d = 70'(p) * 70'(q) - 70'(r) * 70'(s);
      if (d < 0) d = -d;
      return big_t'(d);
    endfunction

    static function curv_out_t predict_curvature(vec_pair_t v, logic planar,
                                                 logic [CFG_W-1:0] thr);
      curv_out_t r;
      big_t cx, cy, cz, q, s, s3, lhs, rhs, num, y2, cand;
      comp_t vz, az;
      logic [OUT_BITS-1:0] res;
      vz = planar ? '0 : v.vz;
      az = planar ? '0 : v.az;
      cx = cross_term(v.vy, az, vz, v.ay);
      cy = cross_term(vz, v.ax, v.vx, az);
      cz = cross_term(v.vx, v.ay, v.vy, v.ax);
      q = cx * cx + cy * cy + cz * cz;
      s = mag_of(v.vx) * mag_of(v.vx) + mag_of(v.vy) * mag_of(v.vy) + mag_of(vz) * mag_of(vz);
      s3 = s * s * s;
      lhs = s3 << 64;
      rhs = (big_t'(thr) * big_t'(thr)) << (6 * FRAC_BITS_DEF);
      r = '0;
      if (lhs <= rhs) begin
        r.too_slow = 1'b1;
        return r;
      end
      num = q << (4 * FRAC_BITS_DEF);
      if ((s3 << (2 * OUT_BITS)) <= num) begin
        r.curvature = '1;
        r.clipped = 1'b1;
        return r;
      end
      // Bit-by-bit square root of num / s3, truncated.
      res = '0;
      for (int b = OUT_BITS - 1; b >= 0; b--) begin
        cand = big_t'(res | (OUT_BITS'(1) << b));
        y2 = cand * cand * s3;
        if (y2 <= num) res = cand[OUT_BITS-1:0];
      end
      r.curvature = res;
      return r;
    endfunction

    function void note_pair(vec_pair_t v, logic planar, logic [CFG_W-1:0] thr);
      pending_curv.push_back(predict_curvature(v, planar, thr));
    endfunction

    function void check_result(curv_out_t got);
      curv_out_t exp_r;
      if (pending_curv.size() == 0) begin
        $error("result with nothing pending: curvature %h", got.curvature);
        mismatches++;
        return;
      end
      exp_r = pending_curv.pop_front();
      if (got.curvature !== exp_r.curvature) begin
        $error("curvature: expected %h, got %h", exp_r.curvature, got.curvature);
        mismatches++;
      end
      if (got.too_slow !== exp_r.too_slow) begin
        $error("speed_too_low: expected %b, got %b", exp_r.too_slow, got.too_slow);
        mismatches++;
      end
      if (got.clipped !== exp_r.clipped) begin
        $error("saturated: expected %b, got %b", exp_r.clipped, got.clipped);
        mismatches++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  cfg_idx_t             cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  pcd_item_if   item_ch();
  pcd_result_if result_ch();

  path_curvature_from_derivatives_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .item     (item_ch.sink),
    .result   (result_ch.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  curvature_ledger  ledger = new();
  logic             planar_now;   // our copy of dimension_mode, inverted
  logic [CFG_W-1:0] thr_now;      // our copy of min_speed_cubed
  bit               sink_calm;    // when set, the sink never stalls

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous ceiling on the whole run.
  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

  // Pick a stall length: mostly short, now and then long.
  function automatic int pick_gap();
    if ($urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Result side: toggle ready at random, check every transfer out.
  int sink_hold = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready)
        ledger.check_result({result_ch.curvature, result_ch.speed_too_low,
                             result_ch.saturated});
      if (sink_hold > 0) begin
        result_ch.ready <= 1'b0;
        sink_hold <= sink_hold - 1;
      end else begin
        result_ch.ready <= 1'b1;
        if (!sink_calm) sink_hold <= pick_gap();
      end
    end
  end

  // Write one register, then wait for the threshold to settle inside.
  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    if (idx == REG_DIMENSION_MODE) planar_now = ~val[0];
    else thr_now = val;
    repeat (4) @(posedge clk);
  endtask

  // Present one pair and hold it until transferred; then maybe drop valid for a gap.
  task automatic send_pair(vec_pair_t v, bit allow_gap);
    int gap;
    item_ch.valid <= 1'b1;
    item_ch.vel_x <= v.vx;
    item_ch.vel_y <= v.vy;
    item_ch.vel_z <= v.vz;
    item_ch.acc_x <= v.ax;
    item_ch.acc_y <= v.ay;
    item_ch.acc_z <= v.az;
    do @(posedge clk); while (!item_ch.ready);
    ledger.note_pair(v, planar_now, thr_now);
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for the block to drain, then let the pipeline settle.
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (ledger.pending_curv.size() != 0) @(posedge clk);
    repeat (110) @(posedge clk);
  endtask

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0:       return comp_t'($urandom());
      1:       return comp_t'($signed(18'($urandom())));
      2:       return comp_t'($signed(26'($urandom())));
      3:       return '0;
      4:       return comp_t'($signed(22'($urandom())));
      default: return comp_t'($signed(30'($urandom())));
    endcase
  endfunction

  function automatic vec_pair_t rand_pair();
    vec_pair_t v;
    v.vx = rand_comp(); v.vy = rand_comp(); v.vz = rand_comp();
    v.ax = rand_comp(); v.ay = rand_comp(); v.az = rand_comp();
    return v;
  endfunction

  localparam comp_t MAXP = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam comp_t MAXN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam comp_t ONE  = comp_t'(1 << FRAC_BITS_DEF);

  task automatic directed_set();
    send_pair('{default: '0}, 1'b0);                       // standing still
    send_pair('{vx: 1, vy: 0, vz: 0, ax: 0, ay: MAXP, az: 0}, 1'b0); // tiny speed
    send_pair('{vx: ONE, vy: 0, vz: 0, ax: 0, ay: ONE, az: 0}, 1'b0);  // unit circle
    send_pair('{vx: ONE, vy: ONE, vz: ONE, ax: 0, ay: 0, az: 0}, 1'b0); // straight line
    send_pair('{vx: MAXP, vy: MAXP, vz: MAXP, ax: MAXP, ay: MAXP, az: MAXP}, 1'b1);
    send_pair('{vx: MAXN, vy: MAXN, vz: MAXN, ax: MAXN, ay: MAXN, az: MAXN}, 1'b1);
    send_pair('{vx: MAXN, vy: MAXP, vz: MAXN, ax: MAXP, ay: MAXN, az: MAXP}, 1'b1);
    send_pair('{vx: 256, vy: 0, vz: 0, ax: 0, ay: MAXN, az: 0}, 1'b1);  // overflow
    send_pair('{vx: MAXP, vy: 0, vz: 0, ax: 0, ay: 1, az: 0}, 1'b1);    // rounds to zero
    send_pair('{vx: 0, vy: 0, vz: ONE, ax: ONE, ay: 0, az: 0}, 1'b1);   // z only
    send_pair('{vx: -ONE, vy: 2 * ONE, vz: -3, ax: MAXN, ay: 5, az: -ONE}, 1'b1);
    send_pair('{vx: 44, vy: 0, vz: 0, ax: 0, ay: 1, az: 0}, 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = REG_DIMENSION_MODE;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.vel_x = '0; item_ch.vel_y = '0; item_ch.vel_z = '0;
    item_ch.acc_x = '0; item_ch.acc_y = '0; item_ch.acc_z = '0;
    planar_now = ~MODE_RESET;
    thr_now = THR_RESET;
    sink_calm = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings first, then a run through the register extremes.
    directed_set();
    drain();
    write_reg(REG_DIMENSION_MODE, CFG_W'(0));
    write_reg(REG_MIN_SPEED_CUBED, '0);
    directed_set();
    drain();
    write_reg(REG_DIMENSION_MODE, CFG_W'(1));
    write_reg(REG_MIN_SPEED_CUBED, '1);
    send_pair('{vx: 40 * ONE, vy: 0, vz: 0, ax: 0, ay: ONE, az: 0}, 1'b0);
    send_pair('{vx: 41 * ONE, vy: 0, vz: 0, ax: 0, ay: ONE, az: 0}, 1'b0);

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(REG_DIMENSION_MODE, CFG_W'($urandom_range(0, 1)));
      case (ph % 3)
        0:       write_reg(REG_MIN_SPEED_CUBED, THR_RESET);
        1:       write_reg(REG_MIN_SPEED_CUBED, CFG_W'({$urandom(), $urandom()}));
        default: write_reg(REG_MIN_SPEED_CUBED, CFG_W'($urandom_range(0, 1 << 20)));
      endcase
      sink_calm = (ph == 2);
      for (int n = 0; n < 85; n++) send_pair(rand_pair(), ph != 4);
    end

    drain();
    if (ledger.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/pcd_pkg.sv
rtl/pcd_ifs.sv
rtl/path_curvature_from_derivatives_unit.sv
tb/tb_path_curvature_from_derivatives_unit.sv
